[design/irt_pkg.sv]
// ============================================================================
// irt_pkg
// Shared types and constants of the notification retry table.
// ============================================================================
`default_nettype none

package irt_pkg;

  // Default number of table entries.
  localparam int unsigned IrtDepthDef = 8;

  // Widths of the stream payloads.
  localparam int unsigned InDataW   = 152;
  localparam int unsigned OutDataW  = 80;
  localparam int unsigned EntriesW  = 4;

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_ACK   = 2'd1,
    OP_PURGE = 2'd2,
    OP_TICK  = 2'd3
  } irt_op_e;

  // Result kinds carried on the output tuser.
  typedef enum logic [2:0] {
    KIND_INFORM = 3'd0,
    KIND_PLAIN  = 3'd1,
    KIND_REJECT = 3'd2,
    KIND_RESEND = 3'd3,
    KIND_DONE   = 3'd4
  } irt_kind_e;

  // Engine sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_ERD,
    ST_EOUT,
    ST_RES
  } irt_state_e;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  tag;
    logic [31:0] addr;
    logic [7:0]  retries;
    logic [30:0] timeout;
    logic [31:0] sent;
  } irt_entry_t;

  // One operation as accepted on the input.
  typedef struct packed {
    irt_op_e     op;
    logic [31:0] id;
    logic [7:0]  tag;
    logic [31:0] addr;
    logic        needs_ack;
    logic        replace;
    logic [7:0]  retry_limit;
    logic [30:0] timeout;
    logic [31:0] now;
  } irt_req_t;

  // One result leaving the engine.
  typedef struct packed {
    irt_kind_e           kind;
    logic [31:0]         id;
    logic [7:0]          tag;
    logic [31:0]         addr;
    logic [EntriesW-1:0] entries;
    logic                last;
  } irt_res_t;

endpackage

`default_nettype wire

[design/irt_ram.sv]
// ============================================================================
// irt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
`default_nettype none

module irt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [(Depth>1?$clog2(Depth):1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [(Depth>1?$clog2(Depth):1)-1:0] raddr_i,
  output      logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/irt_engine.sv]
// ============================================================================
// irt_engine
// Sequencer that scans, compacts and updates the entry memory per operation.
// ============================================================================
`default_nettype none

module irt_engine #(
  parameter int unsigned Depth = irt_pkg::IrtDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output      logic              req_ready_o,
  input  wire irt_pkg::irt_req_t req_i,
  output      logic              res_valid_o,
  input  wire logic              res_ready_i,
  output      irt_pkg::irt_res_t res_o,
  output      logic [$clog2(Depth+1)-1:0] count_o
);
  import irt_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [CW-1:0] DepthC = CW'(Depth);

  irt_state_e state_q, state_d;
  irt_req_t   req_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] wr_idx_q, wr_idx_d;
  logic          pend_q, pend_d;
  logic [Depth-1:0] flag_q, flag_d;
  irt_kind_e     kind_q, kind_d;

  // Memory port signals.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  irt_entry_t    ram_wdata, ram_rdata;

  logic          hit, expired;
  logic [31:0]   age;
  irt_entry_t    upd;

  irt_ram #(.Width($bits(irt_entry_t)), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Per-entry decision for the entry whose read data is present.
  always_comb begin
    age     = req_q.now - ram_rdata.sent;
    expired = age > {1'b0, ram_rdata.timeout};
    upd     = ram_rdata;
    unique case (req_q.op)
      OP_ACK:  hit = ram_rdata.id == req_q.id;
      OP_TICK: hit = expired && (ram_rdata.retries == 8'd0);
      default: hit = ram_rdata.tag == req_q.tag;
    endcase
    if (req_q.op == OP_TICK && expired) begin
      upd.sent    = req_q.now;
      upd.retries = ram_rdata.retries - 8'd1;
    end
  end

  // Registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      pend_q   <= 1'b0;
      flag_q   <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      pend_q   <= pend_d;
      flag_q   <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    kind_q <= kind_d;
  end

  // Next state and outputs.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    pend_d      = 1'b0;
    flag_d      = flag_q;
    kind_d      = kind_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = wr_idx_q[AW-1:0];
    ram_raddr   = rd_idx_q[AW-1:0];
    ram_wdata   = upd;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.entries = EntriesW'(count_q);

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        rd_idx_d    = '0;
        wr_idx_d    = '0;
        flag_d      = '0;
        if (req_valid_i) begin
          if (req_i.op == OP_SEND && !req_i.replace) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      // Pipelined read of every entry with in-place compaction behind it.
      ST_SCAN: begin
        if (rd_idx_q < count_q) begin
          ram_re   = 1'b1;
          pend_d   = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (pend_q) begin
          if (!hit) begin
            ram_we   = 1'b1;
            wr_idx_d = wr_idx_q + 1'b1;
            if (req_q.op == OP_TICK && expired) begin
              flag_d[wr_idx_q[AW-1:0]] = 1'b1;
            end
          end
        end else if (rd_idx_q >= count_q) begin
          count_d  = wr_idx_q;
          rd_idx_d = '0;
          unique case (req_q.op)
            OP_SEND: state_d = ST_FIN;
            OP_TICK: state_d = ST_ERD;
            default: state_d = ST_RES;
          endcase
        end
      end

      // Send: append when acknowledged and room is left.
      ST_FIN: begin
        ram_waddr         = count_q[AW-1:0];
        ram_wdata.id      = req_q.id;
        ram_wdata.tag     = req_q.tag;
        ram_wdata.addr    = req_q.addr;
        ram_wdata.retries = req_q.retry_limit;
        ram_wdata.timeout = req_q.timeout;
        ram_wdata.sent    = req_q.now;
        if (!req_q.needs_ack) begin
          kind_d = KIND_PLAIN;
        end else if (count_q >= DepthC) begin
          kind_d = KIND_REJECT;
        end else begin
          kind_d  = KIND_INFORM;
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
        end
        state_d = ST_RES;
      end

      // Tick: second pass over the compacted table to emit resends.
      ST_ERD: begin
        if (rd_idx_q >= count_q) begin
          state_d = ST_RES;
        end else if (flag_q[rd_idx_q[AW-1:0]]) begin
          ram_re  = 1'b1;
          state_d = ST_EOUT;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end

      ST_EOUT: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_RESEND;
        res_o.id    = ram_rdata.id;
        res_o.tag   = ram_rdata.tag;
        res_o.addr  = ram_rdata.addr;
        if (res_ready_i) begin
          rd_idx_d = rd_idx_q + 1'b1;
          state_d  = ST_ERD;
        end
      end

      // Final result of the operation.
      ST_RES: begin
        res_valid_o = 1'b1;
        res_o.last  = 1'b1;
        unique case (req_q.op)
          OP_SEND: begin
            res_o.kind = kind_q;
            res_o.id   = req_q.id;
            res_o.tag  = req_q.tag;
            res_o.addr = req_q.addr;
          end
          OP_ACK: begin
            res_o.kind = KIND_DONE;
            res_o.id   = req_q.id;
          end
          OP_PURGE: begin
            res_o.kind = KIND_DONE;
            res_o.tag  = req_q.tag;
          end
          default: res_o.kind = KIND_DONE;
        endcase
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

[design/inform_retry_table_top.sv]
// ============================================================================
// inform_retry_table_top
// Ordered table of pending acknowledged notifications with timed resends.
// ============================================================================
//
// Channel  Direction  tuser          tdata / tlast
// s_axis   in         operation      request fields, no tlast
// m_axis   out        kind           result fields, tlast marks final result
//
// A send without purge skips the scan; ack, purge and purged sends read each
// entry once on the single memory read port, with compaction written behind
// the reads. A tick adds a second pass over the table and one read per
// resend. One operation is worked at a time.
// Reset empties the table at once; entry contents need no clearing.
// A stalled output holds the engine; the output register frees the engine
// for the next transfer while the final result waits.
`default_nettype none

module inform_retry_table_top #(
  parameter int unsigned TableDepth = irt_pkg::IrtDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  // tuser: operation[1:0]
  input  wire logic [1:0]                   s_axis_tuser,
  // tdata: request_id[31:0], source_tag[39:32], dest_addr[71:40],
  //        needs_ack[72], replace_queued[73], retry_limit[81:74],
  //        timeout_ms[112:82], now_ms[144:113], zero fill[151:145]
  input  wire logic [irt_pkg::InDataW-1:0]  s_axis_tdata,
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // tuser: kind[2:0]
  output      logic [2:0]                   m_axis_tuser,
  // tdata: request_id_res[31:0], source_tag_res[39:32], dest_addr_res[71:40],
  //        entries_left[75:72], zero fill[79:76]
  output      logic [irt_pkg::OutDataW-1:0] m_axis_tdata,
  output      logic                         m_axis_tlast
);
  import irt_pkg::*;

  localparam int unsigned CW = $clog2(TableDepth + 1);

  irt_req_t      req;
  irt_res_t      res, out_q;
  logic          res_valid, res_ready, out_valid_q;
  logic [CW-1:0] count;

  // Unpack the input transfer.
  always_comb begin
    req.op          = irt_op_e'(s_axis_tuser);
    req.id          = s_axis_tdata[31:0];
    req.tag         = s_axis_tdata[39:32];
    req.addr        = s_axis_tdata[71:40];
    req.needs_ack   = s_axis_tdata[72];
    req.replace     = s_axis_tdata[73];
    req.retry_limit = s_axis_tdata[81:74];
    req.timeout     = s_axis_tdata[112:82];
    req.now         = s_axis_tdata[144:113];
  end

  irt_engine #(.Depth(TableDepth)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .count_o     (count)
  );

  // Output register.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {4'd0, out_q.entries, out_q.addr, out_q.tag, out_q.id};

`ifndef ASSERT_OFF
  // The table never holds more entries than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(TableDepth))
    else $error("entry count above table depth");

  // An accepted operation keeps the engine busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("engine ready right after a transfer");

  // A resend is never the final result of an operation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_RESEND) |-> !m_axis_tlast)
    else $error("resend marked last");
`endif

endmodule

`default_nettype wire

[sim/inform_retry_table_top_tb.sv]
// ----------------------------------------------------------------------------
// inform_retry_table_top_tb
// Self-checking bench for the notification retry table. Operations go in on
// the input stream; a local table predictor computes every expected result
// and a monitor compares each output transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module inform_retry_table_top_tb;
  import irt_pkg::*;

  localparam int unsigned Depth = 8;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    irt_kind_e   kind;
    logic [31:0] id;
    logic [7:0]  tag;
    logic [31:0] addr;
    logic [3:0]  entries;
    logic        last;
  } result_t;

  typedef struct {
    logic [31:0] id;
    logic [7:0]  tag;
    logic [31:0] addr;
    logic [7:0]  retries;
    logic [30:0] timeout;
    logic [31:0] sent;
  } pending_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [1:0] s_axis_tuser = '0;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2:0] m_axis_tuser;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tlast;

  inform_retry_table_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and the queue of results still to arrive.
  pending_t  table_q[$];
  result_t   awaited_q[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        errors = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        cycles = 0;
  logic [31:0] clock_ms = 0;

  function automatic void expect_result(irt_kind_e k, logic [31:0] id, logic [7:0] tag,
                                        logic [31:0] addr, logic lst);
    result_t r;
    r.kind = k; r.id = id; r.tag = tag; r.addr = addr; r.last = lst;
    r.entries = 4'(table_q.size());
    awaited_q.push_back(r);
  endfunction

  function automatic void drop_by_tag(logic [7:0] tag);
    pending_t kept[$];
    foreach (table_q[i]) if (table_q[i].tag != tag) kept.push_back(table_q[i]);
    table_q = kept;
  endfunction

  // Works out the results of one operation and updates the table copy.
  function automatic void predict_table(irt_op_e op, logic [31:0] id, logic [7:0] tag,
                                        logic [31:0] addr, logic ack, logic repl,
                                        logic [7:0] lim, logic [30:0] tmo,
                                        logic [31:0] now);
    pending_t kept[$];
    pending_t p;
    result_t resends[$];
    result_t r;
    case (op)
      OP_SEND: begin
        if (repl) drop_by_tag(tag);
        if (!ack) begin
          expect_result(KIND_PLAIN, id, tag, addr, 1'b1);
        end else if (table_q.size() >= Depth) begin
          expect_result(KIND_REJECT, id, tag, addr, 1'b1);
        end else begin
          p.id = id; p.tag = tag; p.addr = addr; p.retries = lim;
          p.timeout = tmo; p.sent = now;
          table_q.push_back(p);
          expect_result(KIND_INFORM, id, tag, addr, 1'b1);
        end
      end
      OP_ACK: begin
        foreach (table_q[i]) if (table_q[i].id != id) kept.push_back(table_q[i]);
        table_q = kept;
        expect_result(KIND_DONE, id, '0, '0, 1'b1);
      end
      OP_PURGE: begin
        drop_by_tag(tag);
        expect_result(KIND_DONE, '0, tag, '0, 1'b1);
      end
      default: begin
        foreach (table_q[i]) begin
          p = table_q[i];
          if ((now - p.sent) > {1'b0, p.timeout}) begin
            if (p.retries == 0) continue;
            r.kind = KIND_RESEND; r.id = p.id; r.tag = p.tag; r.addr = p.addr;
            r.last = 1'b0;
            resends.push_back(r);
            p.sent = now;
            p.retries = p.retries - 1;
          end
          kept.push_back(p);
        end
        table_q = kept;
        foreach (resends[i]) begin
          r = resends[i];
          r.entries = 4'(table_q.size());
          awaited_q.push_back(r);
        end
        expect_result(KIND_DONE, '0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // Drives one operation and waits for its transfer. Valid stays high after a
  // transfer until the next item replaces it or an idle cycle clears it.
  task automatic send_op(irt_op_e op, logic [31:0] id, logic [7:0] tag, logic [31:0] addr,
                         logic ack, logic repl, logic [7:0] lim, logic [30:0] tmo,
                         logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    predict_table(op, id, tag, addr, ack, repl, lim, tmo, now);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, now, tmo, lim, repl, ack, addr, tag, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_tick(logic [31:0] now);
    send_op(OP_TICK, $urandom, 8'($urandom), $urandom, 1'($urandom), 1'($urandom),
            8'($urandom), 31'($urandom), now);
  endtask

  // Ready generation and result checking.
  always @(posedge clk_i) begin
    result_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("inform_retry_table_top verification failed");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d id %h", $time, m_axis_tuser,
                 m_axis_tdata[31:0]);
        errors <= errors + 1;
      end else begin
        e = awaited_q.pop_front();
        if (m_axis_tuser != e.kind || m_axis_tdata[31:0] != e.id ||
            m_axis_tdata[39:32] != e.tag || m_axis_tdata[71:40] != e.addr ||
            m_axis_tdata[75:72] != e.entries || m_axis_tlast != e.last) begin
          $display("%0t: expected kind %0d id %h tag %h addr %h n %0d last %b",
                   $time, e.kind, e.id, e.tag, e.addr, e.entries, e.last);
          $display("%0t: actual   kind %0d id %h tag %h addr %h n %0d last %b",
                   $time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32],
                   m_axis_tdata[71:40], m_axis_tdata[75:72], m_axis_tlast);
          errors <= errors + 1;
        end
      end
    end
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Fills the table, hits full, acks, purges and drives expiry with wrap.
  task automatic test_directed();
    send_op(OP_SEND, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'hFF,
            31'h7FFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < Depth; i++)
      send_op(OP_SEND, 32'(i), 8'(i % 3), 32'hC0A8_0000 + i, 1'b1, 1'b0,
              8'(i % 2), 31'(10 + i), 32'hFFFF_FFF0);
    send_op(OP_SEND, 32'h55, 8'h7, 32'h0, 1'b1, 1'b0, 8'd1, 31'd5, 32'd0);
    send_op(OP_SEND, 32'h56, 8'h1, 32'h1, 1'b1, 1'b1, 8'hFF, 31'd0, 32'hFFFF_FFF0);
    send_tick(32'hFFFF_FFFA);
    send_tick(32'd20);
    send_tick(32'd40);
    send_op(OP_ACK, 32'd1, '0, '0, 1'b0, 1'b0, '0, '0, '0);
    send_op(OP_ACK, 32'hDEAD, '0, '0, 1'b0, 1'b0, '0, '0, '0);
    send_op(OP_PURGE, '0, 8'h1, '0, 1'b0, 1'b0, '0, '0, '0);
    send_op(OP_PURGE, '0, 8'h0, '0, 1'b0, 1'b0, '0, '0, '0);
    send_op(OP_SEND, 32'd0, 8'h00, 32'd0, 1'b1, 1'b0, 8'd0, 31'h7FFF_FFFF, 32'd0);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'd100);
    clock_ms = 32'd200;
  endtask

  // Mostly realistic traffic on a small id and tag space plus wild values.
  task automatic test_random(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      clock_ms += $urandom_range(30);
      if (pick < 45)
        send_op(OP_SEND, ($urandom_range(9) == 0) ? $urandom : $urandom_range(15),
                ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5)),
                $urandom, ($urandom_range(4) != 0), ($urandom_range(3) == 0),
                ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
                ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(60)),
                ($urandom_range(19) == 0) ? $urandom : clock_ms);
      else if (pick < 60)
        send_op(OP_ACK, ($urandom_range(9) == 0) ? $urandom : $urandom_range(15),
                8'($urandom), $urandom, 1'($urandom), 1'($urandom), 8'($urandom),
                31'($urandom), $urandom);
      else if (pick < 70)
        send_op(OP_PURGE, $urandom, 8'($urandom_range(6)), $urandom, 1'($urandom),
                1'($urandom), 8'($urandom), 31'($urandom), $urandom);
      else
        send_tick(($urandom_range(19) == 0) ? $urandom : clock_ms);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 28; recv_idle_pct = 71;
    test_directed();
    test_random(60);
    send_idle_pct = 71; recv_idle_pct = 28;
    test_random(60);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(60);
    drain_results();
    $display("Covered %0d operations and %0d results across three idle mixes,",
             items_sent, results_seen);
    $display("including full table rejects, wrapped time expiry and purges.");
    if (errors == 0) begin
      $display("inform_retry_table_top verification clean");
    end else begin
      $display("inform_retry_table_top verification failed");
    end
    $finish;
  end

endmodule
